@@ sv/sbfr_pkg.sv @@
// Shared types and constants for the start byte frame receiver.
package sbfr_pkg;

   localparam logic [7:0] START_BYTE = 8'h61;

   typedef struct packed {
      logic bank;
      logic short_mode;
   } desc_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [3:0] byte_position;
      logic       frame_last;
   } rsp_item_type;

endpackage

@@ sv/sbfr_queue.sv @@
// Two-entry queue of completed-frame descriptors between front and back.
module sbfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sbfr_pkg::desc_type push_desc,
   output logic               full,
   output logic               head_valid,
   output sbfr_pkg::desc_type head_desc,
   input  logic               pop
);
   import sbfr_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop && head_valid) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push && !full, pop && head_valid})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

@@ sv/sbfr_front.sv @@
// Front end: mode register, start byte detection and frame fill into the store.
module sbfr_front #(
   parameter int LONG_LEN  = 12,
   parameter int SHORT_LEN = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               push,
   input  logic [7:0]         rx_byte,
   input  logic               q_full,
   output logic               q_push,
   output sbfr_pkg::desc_type q_desc,
   output logic               mem_we,
   output logic [$clog2((LONG_LEN > SHORT_LEN) ? LONG_LEN : SHORT_LEN):0] mem_addr,
   output logic [7:0]         mem_data
);
   import sbfr_pkg::*;

   localparam int STORE_DEPTH = (LONG_LEN > SHORT_LEN) ? LONG_LEN : SHORT_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(LONG_LEN);
   localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(SHORT_LEN);

   logic             mode_ff, mode_in;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] len;
   logic [CNT_W-1:0] eff;
   logic             accept;
   logic             is_start;
   logic [ADDR_W-1:0] wr_idx;

   always_comb begin
      mode_in  = mode_ff;
      bank_in  = bank_ff;
      fill_in  = fill_ff;
      q_push   = 1'b0;
      mem_we   = 1'b0;
      wr_idx   = '0;
      len      = mode_ff ? LEN_SHORT : LEN_LONG;
      eff      = (fill_ff >= len) ? '0 : fill_ff;
      accept   = push && !q_full;
      is_start = (rx_byte == START_BYTE);
      if (csr_write_enable) begin
         mode_in = csr_write_data;
         fill_in = '0;
      end else if (accept) begin
         fill_in = eff;
         if (eff == '0) begin
            if (is_start) begin
               mem_we  = 1'b1;
               fill_in = CNT_W'(1);
            end
         end else if (is_start && (!mode_ff || eff < len - CNT_W'(1))) begin
            mem_we  = 1'b1;
            fill_in = CNT_W'(1);
         end else begin
            mem_we  = 1'b1;
            wr_idx  = eff[ADDR_W-1:0];
            fill_in = eff + CNT_W'(1);
            if (eff + CNT_W'(1) == len) begin
               fill_in = '0;
               q_push  = 1'b1;
               bank_in = ~bank_ff;
            end
         end
      end
   end

   assign mem_addr          = {bank_ff, wr_idx};
   assign mem_data          = rx_byte;
   assign q_desc.bank       = bank_ff;
   assign q_desc.short_mode = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         bank_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         bank_ff <= bank_in;
         fill_ff <= fill_in;
      end
   end

endmodule

@@ sv/sbfr_back.sv @@
// Back end: double-banked frame store, readout sequencer and result queue.
module sbfr_back #(
   parameter int LONG_LEN  = 12,
   parameter int SHORT_LEN = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   mem_we,
   input  logic [$clog2((LONG_LEN > SHORT_LEN) ? LONG_LEN : SHORT_LEN):0] mem_addr,
   input  logic [7:0]             mem_data,
   input  logic                   head_valid,
   input  sbfr_pkg::desc_type     head_desc,
   output logic                   q_pop,
   output logic                   empty,
   input  logic                   pop,
   output sbfr_pkg::rsp_item_type rsp_item
);
   import sbfr_pkg::*;

   localparam int STORE_DEPTH = (LONG_LEN > SHORT_LEN) ? LONG_LEN : SHORT_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_LONG  = ADDR_W'(LONG_LEN - 1);
   localparam logic [ADDR_W-1:0] LAST_SHORT = ADDR_W'(SHORT_LEN - 1);

   logic [7:0] mem [0:(2 << ADDR_W) - 1];

   logic [ADDR_W-1:0]   rd_pos_ff, rd_pos_in;
   logic                inflight_ff;
   logic [7:0]          rd_data_ff;
   logic [3:0]          meta_pos_ff;
   logic                meta_last_ff;
   logic [ADDR_W-1:0]   last_pos;
   logic [ADDR_W+3:0]   pos_ext;
   logic                is_last;
   logic                issue;
   logic                out_pop;
   logic [2:0]          occ;

   rsp_item_type out_ff [2];
   logic         out_wr_ff, out_rd_ff;
   logic [1:0]   out_cnt_ff, out_cnt_in;

   always_comb begin
      last_pos  = head_desc.short_mode ? LAST_SHORT : LAST_LONG;
      is_last   = (rd_pos_ff == last_pos);
      pos_ext   = {4'b0000, rd_pos_ff};
      out_pop   = pop && !empty;
      occ       = {1'b0, out_cnt_ff} + {2'b00, inflight_ff} - {2'b00, out_pop};
      issue     = head_valid && (occ < 3'd2);
      q_pop     = issue && is_last;
      rd_pos_in = rd_pos_ff;
      if (issue) begin
         rd_pos_in = is_last ? '0 : rd_pos_ff + ADDR_W'(1);
      end
      case ({inflight_ff, out_pop})
         2'b10:   out_cnt_in = out_cnt_ff + 2'd1;
         2'b01:   out_cnt_in = out_cnt_ff - 2'd1;
         default: out_cnt_in = out_cnt_ff;
      endcase
   end

   assign empty    = (out_cnt_ff == 2'd0);
   assign rsp_item = out_ff[out_rd_ff];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
      rd_data_ff   <= mem[{head_desc.bank, rd_pos_ff}];
      meta_pos_ff  <= pos_ext[3:0];
      meta_last_ff <= is_last;
      if (inflight_ff) begin
         out_ff[out_wr_ff] <= '{frame_byte: rd_data_ff, byte_position: meta_pos_ff,
                                frame_last: meta_last_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pos_ff   <= '0;
         inflight_ff <= 1'b0;
         out_wr_ff   <= 1'b0;
         out_rd_ff   <= 1'b0;
         out_cnt_ff  <= 2'd0;
      end else begin
         rd_pos_ff   <= rd_pos_in;
         inflight_ff <= issue;
         out_cnt_ff  <= out_cnt_in;
         if (inflight_ff) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
      end
   end

endmodule

@@ sv/start_byte_frame_receiver.sv @@
// Top level of the start byte frame receiver.
// Input: one byte per cycle if not full; full only while both banks await readout.
// Readout: a frame passes the descriptor queue, store read register and result queue.
// Output: one result per frame byte, one per cycle while popped; one store read port.
// Reset: synchronous; clears mode, fill count and queues. Store content is left as is.
module start_byte_frame_receiver #(
   parameter int LONG_LEN  = 12,
   parameter int SHORT_LEN = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_rx_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_frame_byte,
   output logic [3:0] rsp_byte_position,
   output logic       rsp_frame_last,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import sbfr_pkg::*;

   localparam int STORE_DEPTH = (LONG_LEN > SHORT_LEN) ? LONG_LEN : SHORT_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            head_valid;
   desc_type        q_desc;
   desc_type        head_desc;
   logic            mem_we;
   logic [ADDR_W:0] mem_addr;
   logic [7:0]      mem_data;
   rsp_item_type    rsp_item;

   sbfr_front #(.LONG_LEN(LONG_LEN), .SHORT_LEN(SHORT_LEN)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .rx_byte          (req_rx_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_desc           (q_desc),
      .mem_we           (mem_we),
      .mem_addr         (mem_addr),
      .mem_data         (mem_data)
   );

   sbfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_desc),
      .full       (q_full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (q_pop)
   );

   sbfr_back #(.LONG_LEN(LONG_LEN), .SHORT_LEN(SHORT_LEN)) u_back (
      .clock      (clock),
      .reset      (reset),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_data   (mem_data),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .q_pop      (q_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_item   (rsp_item)
   );

   assign full              = q_full;
   assign rsp_frame_byte    = rsp_item.frame_byte;
   assign rsp_byte_position = rsp_item.byte_position;
   assign rsp_frame_last    = rsp_item.frame_last;

   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("frame descriptor pushed into full queue");

   a_no_queue_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && !head_valid))
      else $error("readout finished with no pending frame");

   a_cfg_clears_fill: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !q_push)
      else $error("frame completed right after mode write");

endmodule

@@ dv/sbfr_frame_check.sv @@
// Watches both channels of the frame receiver, predicts each frame transfer and compares.
module sbfr_frame_check #(
   parameter int LONG_LEN  = 12,
   parameter int SHORT_LEN = 5
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       full,
   input  logic [7:0] req_rx_byte,
   input  logic       empty,
   input  logic       pop,
   input  logic [7:0] rsp_frame_byte,
   input  logic [3:0] rsp_byte_position,
   input  logic       rsp_frame_last,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   output int         fail_count,
   output int         pending,
   output int         checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sbfr_pkg::*;

   localparam int DEPTH = LONG_LEN > SHORT_LEN ? LONG_LEN : SHORT_LEN;

   logic         mode_short = 1'b0;
   int unsigned  fill = 0;
   logic [7:0]   held [DEPTH];
   rsp_item_type awaited [$];
   int           errors = 0;
   int           checked = 0;

   assign fail_count    = errors;
   assign checked_count = checked;

   task automatic flag(input string what, input rsp_item_type want, input rsp_item_type got);
      errors++;
      if (errors <= 10) begin
         $display("%0t sbfr_frame_check: %s: expected byte %02h pos %0d last %0b,",
                  $time, what, want.frame_byte, want.byte_position, want.frame_last);
         $display("   got byte %02h pos %0d last %0b",
                  got.frame_byte, got.byte_position, got.frame_last);
      end
   endtask

   task automatic take_byte(input logic [7:0] b);
      int unsigned  len;
      int unsigned  i;
      rsp_item_type r;
      len = mode_short ? SHORT_LEN : LONG_LEN;
      if (fill >= len) fill = 0;
      if (fill == 0) begin
         if (b == START_BYTE) begin
            held[0] = b;
            fill = 1;
         end
      end else if (b == START_BYTE && (!mode_short || fill < len - 1)) begin
         held[0] = b;
         fill = 1;
      end else begin
         if (fill < DEPTH) held[fill] = b;
         fill++;
      end
      if (fill == len) begin
         fill = 0;
         for (i = 0; i < len && i < DEPTH; i++) begin
            r.frame_byte    = held[i];
            r.byte_position = i[3:0];
            r.frame_last    = (i + 1 == len);
            awaited.push_back(r);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         mode_short = 1'b0;
         fill = 0;
         awaited.delete();
      end else begin
         if (csr_write_enable) begin
            mode_short = csr_write_data;
            fill = 0;
         end
         if (pop && !empty) begin
            got.frame_byte    = rsp_frame_byte;
            got.byte_position = rsp_byte_position;
            got.frame_last    = rsp_frame_last;
            checked++;
            if (awaited.size() == 0) begin
               flag("unexpected transfer", '0, got);
            end else begin
               want = awaited.pop_front();
               if (got !== want) flag("mismatch", want, got);
            end
         end
         if (push && !full) take_byte(req_rx_byte);
      end
      pending <= awaited.size();
   end

endmodule

@@ dv/testbench.sv @@
// Top of the frame receiver testbench: clock, reset, byte and mode stimulus, verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sbfr_pkg::*;

   localparam int LONG_LEN    = 12;
   localparam int SHORT_LEN   = 5;
   localparam int QUIET_LIMIT = 2000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       pop = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       full;
   logic       empty;
   logic [7:0] rsp_frame_byte;
   logic [3:0] rsp_byte_position;
   logic       rsp_frame_last;
   int         fail_count;
   int         pending;
   int         checked_count;

   int   send_idle_pct = 0;
   int   pop_stall_pct = 0;
   int   bytes_sent = 0;
   int   frame_bytes = 0;
   int   quiet = 0;
   logic mode_short = 1'b0;

   start_byte_frame_receiver #(.LONG_LEN(LONG_LEN), .SHORT_LEN(SHORT_LEN)) dut (.*);

   sbfr_frame_check #(.LONG_LEN(LONG_LEN), .SHORT_LEN(SHORT_LEN)) frame_check (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("testbench: no transfer for %0d cycles", QUIET_LIMIT);
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      mode_short = m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] data_byte();
      return ($urandom_range(19) == 0) ? START_BYTE : 8'($urandom);
   endfunction

   task automatic send_frame();
      int len;
      len = mode_short ? SHORT_LEN : LONG_LEN;
      send_byte(START_BYTE);
      repeat (len - 1) send_byte(data_byte());
      frame_bytes += len;
   endtask

   task automatic run_traffic(input int goal);
      while (frame_bytes < goal) begin
         if ($urandom_range(3) != 0) send_frame();
         else repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
   endtask

   logic [7:0] long_opening [16] = '{8'h00, 8'hFF, START_BYTE, 8'h5A, START_BYTE,
                                     8'hFF, 8'h00, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                     8'h55, 8'hAA, 8'h60, 8'h62, START_BYTE};
   logic [7:0] short_opening [7] = '{START_BYTE, 8'h00, START_BYTE, 8'hFF, 8'h01,
                                     8'h80, START_BYTE};

   initial begin
      int p;
      int base;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle drop, restart mid-frame, start byte at last long position restarts
      foreach (long_opening[i]) send_byte(long_opening[i]);
      // start byte at last short position is kept and closes the frame
      set_mode(1'b1);
      foreach (short_opening[i]) send_byte(short_opening[i]);

      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 78; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 78; end
            default: begin send_idle_pct = 34; pop_stall_pct = 34; end
         endcase
         set_mode(p == 1 || p == 2);
         base = frame_bytes;
         run_traffic(base + 36);
         if (p == 2) drain();
         run_traffic(base + 72);
      end

      drain();
      $display("testbench: %0d bytes sent, %0d frame bytes checked, long and short frames",
               bytes_sent, checked_count);
      $display("testbench: mode rewrites and four sender/receiver flow-control mixes");
      if (fail_count == 0 && pending == 0) $display("testbench: PASS");
      else $display("testbench: FAIL");
      $finish;
   end

endmodule
